// ----- design/range_min_segment_tree_top_assert.svh -----
// assertion macros for the range-minimum segment tree
// used by range_min_segment_tree_top; needs a clock named clock and a reset named reset
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RMST_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RMST_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rmst_pkg.sv -----
// shared types, sizes and codes for the range-minimum segment tree
// no dependencies
package rmst_pkg;

   localparam int LEAVES    = 1024;
   localparam int LEAF_BITS = $clog2(LEAVES);
   localparam int NODES     = 2 * LEAVES;
   localparam int NODE_BITS = $clog2(NODES);
   localparam int VALUE_W   = 32;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [NODE_BITS-1:0]      node_addr_type;
   typedef logic [NODE_BITS:0]        bound_type;

   localparam value_type INT_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // request codes
   localparam logic REQ_SET   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // signed minimum of two values
   function automatic value_type smin(input value_type a, input value_type b);
      smin = (a <= b) ? a : b;
   endfunction

endpackage

// ----- design/rmst_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/range_min_segment_tree_top.sv -----
// channel  | ports                                              | direction
// req      | req_valid req_stall req_type req_index req_value   | in
//          | req_range_lo req_range_hi                          |
// rsp      | rsp_valid rsp_stall rsp_min_value rsp_empty_range  | out
//
// after reset a clearing pass writes zero to all 2048 tree nodes, req stalled
// a set beat does a leaf write, then one sibling read and one parent write per level
// a query walks bottom up, a left then a right boundary step per level, at most 11 levels
// an empty query skips the walk; set and query timing follows the single node ram read port
// req_stall is high while an item is at work; a query waits at its end while rsp is stalled
//
// top level of the range-minimum segment tree; uses rmst_pkg, rmst_ram and the assert header
`include "range_min_segment_tree_top_assert.svh"

module range_min_segment_tree_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [9:0]          req_index,
   input  rmst_pkg::value_type req_value,
   input  logic [9:0]          req_range_lo,
   input  logic [10:0]         req_range_hi,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rmst_pkg::value_type rsp_min_value,
   output logic                rsp_empty_range
);

   import rmst_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_U_RD = 3'd2;
   localparam logic [2:0] ST_U_WR = 3'd3;
   localparam logic [2:0] ST_Q_L  = 3'd4;
   localparam logic [2:0] ST_Q_R  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]    state_ff, state_in;
   node_addr_type clr_cnt_ff, clr_cnt_in;
   node_addr_type pos_ff, pos_in;
   value_type     cur_ff, cur_in;
   bound_type     l_ff, l_in;
   bound_type     r_ff, r_in;
   value_type     res_ff, res_in;
   logic          empty_ff, empty_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_min_ff, rsp_min_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic            wr_en;
   node_addr_type   wr_addr;
   value_type       wr_data;
   logic            rd_en;
   node_addr_type   rd_addr;
   logic [VALUE_W-1:0] rd_data;
   value_type       rd_value;

   logic          req_beat;
   logic          rsp_free;
   bound_type     hi_sat;
   bound_type     r_dec;
   value_type     upd_min;

   assign rd_value = $signed(rd_data);
   assign req_beat = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign upd_min  = smin(cur_ff, rd_value);
   assign r_dec    = r_ff - bound_type'(1);

   // range end saturated to the leaf count
   always_comb begin
      if ({1'b0, req_range_hi} > bound_type'(LEAVES)) begin
         hi_sat = bound_type'(LEAVES);
      end else begin
         hi_sat = {1'b0, req_range_hi};
      end
   end

   // node storage
   rmst_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer and ram port control
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      pos_in     = pos_ff;
      cur_in     = cur_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      empty_in   = empty_ff;
      pend_in    = 1'b0;
      res_in     = pend_ff ? smin(res_ff, rd_value) : res_ff;
      wr_en      = 1'b0;
      wr_addr    = clr_cnt_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = pos_ff ^ node_addr_type'(1);

      case (state_ff)
         ST_CLR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + node_addr_type'(1);
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               if (req_type == REQ_SET) begin
                  // write the leaf, then walk up
                  wr_en    = 1'b1;
                  wr_addr  = {1'b1, req_index};
                  wr_data  = req_value;
                  pos_in   = {1'b1, req_index};
                  cur_in   = req_value;
                  state_in = ST_U_RD;
               end else begin
                  l_in     = {2'b01, req_range_lo};
                  r_in     = hi_sat + bound_type'(LEAVES);
                  res_in   = INT_MAX;
                  empty_in = (hi_sat <= {2'b00, req_range_lo});
                  state_in = (hi_sat <= {2'b00, req_range_lo}) ? ST_DONE : ST_Q_L;
               end
            end
         end
         ST_U_RD: begin
            // fetch the sibling of the current node
            rd_en    = 1'b1;
            rd_addr  = pos_ff ^ node_addr_type'(1);
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            // parent gets the smaller of the two children
            wr_en   = 1'b1;
            wr_addr = pos_ff >> 1;
            wr_data = upd_min;
            cur_in  = upd_min;
            pos_in  = pos_ff >> 1;
            if (pos_ff[NODE_BITS-1:1] == (NODE_BITS-1)'(1)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_U_RD;
            end
         end
         ST_Q_L: begin
            // left boundary of one level
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  rd_en   = 1'b1;
                  rd_addr = l_ff[NODE_BITS-1:0];
                  pend_in = 1'b1;
                  l_in    = l_ff + bound_type'(1);
               end
               state_in = ST_Q_R;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_Q_R: begin
            // right boundary, then move up one level
            if (r_ff[0]) begin
               rd_en   = 1'b1;
               rd_addr = r_dec[NODE_BITS-1:0];
               pend_in = 1'b1;
               r_in    = r_dec >> 1;
            end else begin
               r_in    = r_ff >> 1;
            end
            l_in     = l_ff >> 1;
            state_in = ST_Q_L;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_min_in   = res_ff;
         rsp_empty_in = empty_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_cnt_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cur_ff       <= cur_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      res_ff       <= res_in;
      empty_ff     <= empty_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_empty_range = rsp_empty_ff;

   // checks
   `RMST_ASSERT_NOW(a_empty_max, rsp_valid && rsp_empty_range, rsp_min_value == INT_MAX, "empty range without max value")
   `RMST_ASSERT_NOW(a_pend_query, pend_ff, state_ff == ST_Q_L || state_ff == ST_Q_R, "pending read outside query walk")
   `RMST_ASSERT_NOW(a_write_states, wr_en, state_ff == ST_CLR || state_ff == ST_IDLE || state_ff == ST_U_WR, "node write outside clear or update")
   `RMST_ASSERT_NEXT(a_upd_path, state_ff == ST_U_WR && pos_ff[NODE_BITS-1:1] != (NODE_BITS-1)'(1), pos_ff != node_addr_type'(0) && pos_ff != node_addr_type'(1), "update walked past the root")

endmodule
